// ----- sv/shift_compensated_min_distance_top_defines.svh -----
// assertion macros for the shift compensated minimum distance block
`ifndef SHIFT_COMPENSATED_MIN_DISTANCE_TOP_DEFINES_SVH
`define SHIFT_COMPENSATED_MIN_DISTANCE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SCMD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scmd assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SCMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scmd assertion failed");

`endif

// ----- sv/scmd_pkg.sv -----
// shared types and constants of the shift compensated minimum distance block
package scmd_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COMPONENTS_DEF  = 4;
  localparam int NCOMP           = 4;
  localparam int FIELD_W         = 16;
  localparam int SHIFT_W         = 17;
  localparam int WEIGHT_W        = 16;
  localparam int DIST_W          = 32;
  // test + shift - ref stays within -131071 to +131070
  localparam int DIFF_W          = 18;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 17;

  localparam logic [DIST_W-1:0] SIGNED_MAX = 32'h7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHIFT_C0  = 3'd0,
    REG_SHIFT_C1  = 3'd1,
    REG_SHIFT_C2  = 3'd2,
    REG_SHIFT_C3  = 3'd3,
    REG_WEIGHT_C0 = 3'd4,
    REG_WEIGHT_C1 = 3'd5,
    REG_WEIGHT_C2 = 3'd6,
    REG_WEIGHT_C3 = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_WEIGHT,
    S_ACCUM,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic weight;
    logic accum;
    logic emit;
  } scmd_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic last;
    logic out_free;
  } scmd_stat_t;

endpackage

// ----- sv/scmd_in_if.sv -----
// request channel carrying one candidate pixel with its test pixel
interface scmd_in_if import scmd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] test_c0;
  logic [FIELD_W-1:0] test_c1;
  logic [FIELD_W-1:0] test_c2;
  logic [FIELD_W-1:0] test_c3;
  logic [FIELD_W-1:0] ref_c0;
  logic [FIELD_W-1:0] ref_c1;
  logic [FIELD_W-1:0] ref_c2;
  logic [FIELD_W-1:0] ref_c3;
  logic               last_candidate;
  logic               last_of_row;

  modport source (
    output valid, test_c0, test_c1, test_c2, test_c3,
    output ref_c0, ref_c1, ref_c2, ref_c3, last_candidate, last_of_row,
    input  ready
  );
  modport sink (
    input  valid, test_c0, test_c1, test_c2, test_c3,
    input  ref_c0, ref_c1, ref_c2, ref_c3, last_candidate, last_of_row,
    output ready
  );
endinterface

// ----- sv/scmd_out_if.sv -----
// result channel carrying best distances and row sums of one window
interface scmd_out_if import scmd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] dist_c0;
  logic [DIST_W-1:0] dist_c1;
  logic [DIST_W-1:0] dist_c2;
  logic [DIST_W-1:0] dist_c3;
  logic [DIST_W-1:0] row_sum_c0;
  logic [DIST_W-1:0] row_sum_c1;
  logic [DIST_W-1:0] row_sum_c2;
  logic [DIST_W-1:0] row_sum_c3;
  logic              row_done;

  modport source (
    output valid, dist_c0, dist_c1, dist_c2, dist_c3,
    output row_sum_c0, row_sum_c1, row_sum_c2, row_sum_c3, row_done,
    input  ready
  );
  modport sink (
    input  valid, dist_c0, dist_c1, dist_c2, dist_c3,
    input  row_sum_c0, row_sum_c1, row_sum_c2, row_sum_c3, row_done,
    output ready
  );
endinterface

// ----- sv/shift_compensated_min_distance_top.sv -----
// top level of the shift compensated minimum distance block
// a candidate passes 4 steps (accept, square, weight, accumulate); a window's last
// candidate adds an emit step to load the output register, held while it is still full
// result valid is registered with that load; a new candidate is taken only in idle
// synchronous active-low reset: shifts 0, weights 1, best error at signed max, sums 0
`include "shift_compensated_min_distance_top_defines.svh"

module shift_compensated_min_distance_top import scmd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COMPONENTS  = COMPONENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  scmd_in_if.sink               in_ch,
  scmd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // command and status between sequencer and datapath
  scmd_cmd_t  cmd;
  scmd_stat_t stat;

  // request payload gathered into per-component lanes
  logic [FIELD_W-1:0] test_s [NCOMP];
  logic [FIELD_W-1:0] cand_s [NCOMP];
  logic [DIST_W-1:0]  out_dist [NCOMP];
  logic [DIST_W-1:0]  out_row  [NCOMP];
  logic               out_valid;
  logic               out_row_done;
  logic               in_ready;

  assign test_s[0] = in_ch.test_c0;
  assign test_s[1] = in_ch.test_c1;
  assign test_s[2] = in_ch.test_c2;
  assign test_s[3] = in_ch.test_c3;
  assign cand_s[0] = in_ch.ref_c0;
  assign cand_s[1] = in_ch.ref_c1;
  assign cand_s[2] = in_ch.ref_c2;
  assign cand_s[3] = in_ch.ref_c3;

  // ready only in the idle state: one request in flight at a time
  scmd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // lanes: diff register, squarer, weight multiplier, then error sum and compare
  scmd_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COMPONENTS  (COMPONENTS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_valid     (in_ch.valid),
    .test_s       (test_s),
    .cand_s       (cand_s),
    .in_last      (in_ch.last_candidate),
    .in_row_end   (in_ch.last_of_row),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ch.ready),
    .out_dist     (out_dist),
    .out_row      (out_row),
    .out_row_done (out_row_done)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.dist_c0    = out_dist[0];
  assign out_ch.dist_c1    = out_dist[1];
  assign out_ch.dist_c2    = out_dist[2];
  assign out_ch.dist_c3    = out_dist[3];
  assign out_ch.row_sum_c0 = out_row[0];
  assign out_ch.row_sum_c1 = out_row[1];
  assign out_ch.row_sum_c2 = out_row[2];
  assign out_ch.row_sum_c3 = out_row[3];
  assign out_ch.row_done   = out_row_done;

  // an accepted request always moves on to the squaring step
  `SCMD_ASSERT_NEXT(a_accept_to_square, in_ch.valid && in_ch.ready, cmd.square)
  // a non-final candidate frees the input right after accumulation
  `SCMD_ASSERT_NEXT(a_mid_window_ready, cmd.accum && !stat.last, in_ch.ready)
  // loading the output register always raises valid
  `SCMD_ASSERT_NEXT(a_emit_valid, cmd.emit, out_ch.valid)
  // a fresh result only appears after an emit step
  `SCMD_ASSERT_IMPL(a_valid_from_emit, $rose(out_ch.valid), $past(cmd.emit))

endmodule

// ----- sv/scmd_datapath.sv -----
// difference, square, weight and minimum tracking lanes with row totals
module scmd_datapath import scmd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COMPONENTS  = COMPONENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scmd_cmd_t             cmd,
  output scmd_stat_t            stat,
  input  logic                  in_valid,
  input  logic [FIELD_W-1:0]    test_s [NCOMP],
  input  logic [FIELD_W-1:0]    cand_s [NCOMP],
  input  logic                  in_last,
  input  logic                  in_row_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DIST_W-1:0]     out_dist [NCOMP],
  output logic [DIST_W-1:0]     out_row [NCOMP],
  output logic                  out_row_done
);

  logic [SHIFT_W-1:0]  shift_r   [NCOMP];
  logic [SHIFT_W-1:0]  shift_nxt [NCOMP];
  logic [WEIGHT_W-1:0] weight_r   [NCOMP];
  logic [WEIGHT_W-1:0] weight_nxt [NCOMP];

  logic [DIFF_W-1:0]   d_r     [NCOMP];
  logic [DIFF_W-1:0]   d_nxt   [NCOMP];
  logic [DIST_W-1:0]   dist_r  [NCOMP];
  logic [DIST_W-1:0]   dist_nxt[NCOMP];
  logic [DIST_W-1:0]   prod_r  [NCOMP];
  logic [DIST_W-1:0]   prod_nxt[NCOMP];
  logic                last_r, last_nxt;
  logic                row_end_r, row_end_nxt;

  logic [DIST_W-1:0]   best_error_r, best_error_nxt;
  logic [DIST_W-1:0]   best_dist_r   [NCOMP];
  logic [DIST_W-1:0]   best_dist_nxt [NCOMP];
  logic [DIST_W-1:0]   row_total_r   [NCOMP];
  logic [DIST_W-1:0]   row_total_nxt [NCOMP];
  logic [DIST_W-1:0]   row_sum       [NCOMP];

  logic                out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]   out_dist_r [NCOMP];
  logic [DIST_W-1:0]   out_row_r  [NCOMP];
  logic                out_row_done_r;

  logic [DIST_W-1:0]   err;
  logic                better;

  // configuration decode
  always_comb begin
    for (int c = 0; c < NCOMP; c++) begin
      shift_nxt[c]  = shift_r[c];
      weight_nxt[c] = weight_r[c];
    end
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SHIFT_C0:  shift_nxt[0]  = cfg_data;
        REG_SHIFT_C1:  shift_nxt[1]  = cfg_data;
        REG_SHIFT_C2:  shift_nxt[2]  = cfg_data;
        REG_SHIFT_C3:  shift_nxt[3]  = cfg_data;
        REG_WEIGHT_C0: weight_nxt[0] = cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_C1: weight_nxt[1] = cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_C2: weight_nxt[2] = cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT_C3: weight_nxt[3] = cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // per-lane arithmetic, one stage per command
  always_comb begin
    logic [DIFF_W-1:0]          t_ext;
    logic [DIFF_W-1:0]          r_ext;
    logic [DIFF_W-1:0]          s_ext;
    logic signed [2*DIFF_W-1:0] sq;
    logic [DIST_W+WEIGHT_W-1:0] wp;
    for (int c = 0; c < NCOMP; c++) begin
      t_ext = DIFF_W'(test_s[c][SAMPLE_BITS-1:0]);
      r_ext = DIFF_W'(cand_s[c][SAMPLE_BITS-1:0]);
      s_ext = {{(DIFF_W-SHIFT_W){shift_r[c][SHIFT_W-1]}}, shift_r[c]};
      if (c < COMPONENTS) d_nxt[c] = t_ext + s_ext - r_ext;
      else                d_nxt[c] = '0;
      sq          = $signed(d_r[c]) * $signed(d_r[c]);
      dist_nxt[c] = sq[DIST_W-1:0];
      wp          = dist_r[c] * weight_r[c];
      prod_nxt[c] = wp[DIST_W-1:0];
    end
  end

  assign last_nxt    = cmd.load ? in_last    : last_r;
  assign row_end_nxt = cmd.load ? in_row_end : row_end_r;

  // weighted error and signed minimum
  always_comb begin
    err = '0;
    for (int c = 0; c < NCOMP; c++) err = err + prod_r[c];
    better = $signed(err) < $signed(best_error_r);
  end

  always_comb begin
    best_error_nxt = best_error_r;
    for (int c = 0; c < NCOMP; c++) begin
      best_dist_nxt[c] = best_dist_r[c];
      row_sum[c]       = row_total_r[c] + best_dist_r[c];
      row_total_nxt[c] = row_total_r[c];
    end
    if (cmd.accum && better) begin
      best_error_nxt = err;
      for (int c = 0; c < NCOMP; c++) best_dist_nxt[c] = dist_r[c];
    end
    if (cmd.emit) begin
      // window done: restart the minimum search, close the row if marked
      best_error_nxt = SIGNED_MAX;
      for (int c = 0; c < NCOMP; c++) begin
        best_dist_nxt[c] = '0;
        row_total_nxt[c] = row_end_r ? '0 : row_sum[c];
      end
    end
  end

  assign out_valid_nxt = cmd.emit | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCOMP; c++) begin
        shift_r[c]     <= '0;
        weight_r[c]    <= WEIGHT_W'(1);
        best_dist_r[c] <= '0;
        row_total_r[c] <= '0;
      end
      best_error_r <= SIGNED_MAX;
      last_r       <= 1'b0;
      row_end_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      for (int c = 0; c < NCOMP; c++) begin
        shift_r[c]     <= shift_nxt[c];
        weight_r[c]    <= weight_nxt[c];
        best_dist_r[c] <= best_dist_nxt[c];
        row_total_r[c] <= row_total_nxt[c];
      end
      best_error_r <= best_error_nxt;
      last_r       <= last_nxt;
      row_end_r    <= row_end_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NCOMP; c++) begin
      if (cmd.load)   d_r[c]    <= d_nxt[c];
      if (cmd.square) dist_r[c] <= dist_nxt[c];
      if (cmd.weight) prod_r[c] <= prod_nxt[c];
      if (cmd.emit) begin
        out_dist_r[c] <= best_dist_r[c];
        out_row_r[c]  <= row_sum[c];
      end
    end
    if (cmd.emit) out_row_done_r <= row_end_r;
  end

  assign stat.in_valid = in_valid;
  assign stat.last     = last_r;
  assign stat.out_free = ~out_valid_r | out_ready;

  assign out_valid    = out_valid_r;
  assign out_dist     = out_dist_r;
  assign out_row      = out_row_r;
  assign out_row_done = out_row_done_r;

endmodule

// ----- sv/scmd_ctrl.sv -----
// sequencer stepping one candidate through the datapath stages
module scmd_ctrl import scmd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  scmd_stat_t stat,
  output scmd_cmd_t  cmd,
  output logic       in_ready
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = S_WEIGHT;
      end
      S_WEIGHT: begin
        cmd.weight = 1'b1;
        state_nxt  = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum = 1'b1;
        state_nxt = stat.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // wait until the output register can take the result
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
